@@ src/modexp_pkg.sv @@
// Shared constants, codes and control types for the modular exponentiation core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package modexp_pkg;

  // Default operand width
  localparam int MEXP_WIDTH = 64;

  // Error code field
  localparam int ERR_W = 2;
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MSG_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MOD_ZERO  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture a message beat and set up the operands
    logic mul_start;   // load the multiplier
    logic mul_sqr;     // multiplier works on base*base, else acc*base
    logic mul_step;    // one shift-and-add step
    logic mul_commit;  // write the finished product back
    logic exp_shift;   // drop the exponent's low bit
    logic out_load;    // move the result into the output register
  } mexp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic error;       // message or modulus rejected
    logic exp_zero;    // working exponent is zero
    logic exp_lsb;     // low bit of the working exponent
    logic exp_last;    // working exponent has no bit above the low one
    logic mul_last;    // multiplier is on its final step
  } mexp_status_t;

endpackage

`default_nettype wire

@@ src/mexp_msg_if.sv @@
// Input channel carrying one message word per beat.
// Depends on modexp_pkg for the default width.
`default_nettype none

interface mexp_msg_if
  import modexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

`default_nettype wire

@@ src/mexp_res_if.sv @@
// Output channel carrying one result word and error code per beat.
// Depends on modexp_pkg for the default width and code width.
`default_nettype none

interface mexp_res_if
  import modexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, output result, output error_code, input ready);
  modport sink   (input valid, input result, input error_code, output ready);
endinterface

`default_nettype wire

@@ src/mexp_dp.sv @@
// Datapath: configuration registers, exponent shifter, bit-serial modular
// multiplier and output register. Depends on modexp_pkg.
`default_nettype none

module mexp_dp
  import modexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDTH-1:0]     cfg_data,
  input  wire logic [WIDTH-1:0]     message,
  input  wire mexp_cmd_t            cmd,
  output mexp_status_t              status,
  output logic [WIDTH-1:0]          result,
  output logic [ERR_W-1:0]          error_code
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int EXT_W = WIDTH + 2;

  logic [WIDTH-1:0] key_exponent;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exp_work;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] acc;
  logic [ERR_W-1:0] err;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic [WIDTH-1:0] mul_acc;
  logic [CNT_W-1:0] mul_cnt;

  logic [EXT_W-1:0] sum;
  logic [EXT_W-1:0] mod_x1;
  logic [EXT_W-1:0] mod_x2;
  logic [WIDTH-1:0] mul_acc_next;
  logic [ERR_W-1:0] err_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_exponent <= WIDTH'(1);
      modulus      <= WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPONENT: key_exponent <= cfg_data;
        CFG_MODULUS:  modulus      <= cfg_data;
        default: ;
      endcase
    end
  end

  // One multiplier step: 2*acc + (bit ? a : 0) lies below 3n, reduce once
  always_comb begin
    sum    = {mul_acc, 1'b0} + (mul_b[WIDTH-1] ? {2'b00, mul_a} : '0);
    mod_x1 = {2'b00, modulus};
    mod_x2 = {1'b0, modulus, 1'b0};
    if (sum >= mod_x2) begin
      mul_acc_next = WIDTH'(sum - mod_x2);
    end else if (sum >= mod_x1) begin
      mul_acc_next = WIDTH'(sum - mod_x1);
    end else begin
      mul_acc_next = WIDTH'(sum);
    end
  end

  // Classify the incoming message
  always_comb begin
    if (modulus == '0) begin
      err_next = ERR_MOD_ZERO;
    end else if (message > modulus) begin
      err_next = ERR_MSG_RANGE;
    end else begin
      err_next = ERR_NONE;
    end
  end

  // Operand registers and multiplier
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err      <= err_next;
      exp_work <= key_exponent;
      base     <= (message == modulus) ? '0 : message;
      acc      <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
    end
    if (cmd.exp_shift) begin
      exp_work <= exp_work >> 1;
    end
    if (cmd.mul_start) begin
      mul_a   <= cmd.mul_sqr ? base : acc;
      mul_b   <= base;
      mul_acc <= '0;
      mul_cnt <= CNT_W'(WIDTH - 1);
    end else if (cmd.mul_step) begin
      mul_acc <= mul_acc_next;
      mul_b   <= mul_b << 1;
      mul_cnt <= mul_cnt - 1'b1;
    end
    if (cmd.mul_commit) begin
      if (cmd.mul_sqr) begin
        base <= mul_acc_next;
      end else begin
        acc <= mul_acc_next;
      end
    end
    // Hold the finished beat until the sink takes it
    if (cmd.out_load) begin
      result     <= (err == ERR_NONE) ? acc : '0;
      error_code <= err;
    end
  end

  assign status.error    = (err != ERR_NONE);
  assign status.exp_zero = (exp_work == '0);
  assign status.exp_lsb  = exp_work[0];
  assign status.exp_last = (exp_work[WIDTH-1:1] == '0);
  assign status.mul_last = (mul_cnt == '0);

endmodule

`default_nettype wire

@@ src/mexp_ctrl.sv @@
// Controller: sequences the square-and-multiply loop over the exponent bits
// and runs the channel handshakes. Depends on modexp_pkg.
`default_nettype none

module mexp_ctrl
  import modexp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire mexp_status_t status,
  output mexp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_NEXT,
    S_DONE
  } state_t;

  state_t state;
  logic   sqr_phase;

  // Decode commands from the current state
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_CHECK: begin
        if (!status.error && !status.exp_zero && status.exp_lsb) begin
          cmd.mul_start = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_step   = 1'b1;
        cmd.mul_sqr    = sqr_phase;
        cmd.mul_commit = status.mul_last;
      end
      S_NEXT: begin
        cmd.exp_shift = 1'b1;
        if (!status.exp_last) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sqr   = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // State, multiply phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sqr_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (status.error || status.exp_zero) begin
            state <= S_DONE;
          end else if (status.exp_lsb) begin
            sqr_phase <= 1'b0;
            state     <= S_MUL;
          end else begin
            state <= S_NEXT;
          end
        end
        S_MUL: begin
          if (status.mul_last) state <= sqr_phase ? S_CHECK : S_NEXT;
        end
        S_NEXT: begin
          if (status.exp_last) begin
            state <= S_DONE;
          end else begin
            sqr_phase <= 1'b1;
            state     <= S_MUL;
          end
        end
        S_DONE: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/modular_exponentiation_core.sv @@
// Top level of the modular exponentiation core: controller plus datapath.
// Depends on modexp_pkg, mexp_msg_if, mexp_res_if, mexp_ctrl and mexp_dp.
//
//   channel    dir  beat contents
//   msg_chan   in   message [WIDTH]
//   res_chan   out  result [WIDTH], error_code [2]
//   cfg port   in   cfg_we, cfg_index (0 exponent, 1 modulus), cfg_data [WIDTH]
//
// One message at a time. Each exponent bit, low bit first, passes a check state,
// a multiply when the bit is set, a shift state and, except after the top bit,
// a square on the single bit-serial modular multiplier. Rejected messages and a
// zero exponent go straight from the check state to the done state. A busy
// output register stalls the core in its done state.
// Reset sets exponent and modulus to 1; there is no clearing pass.
// A finished beat waits in the output register while the next message is taken.
`default_nettype none

module modular_exponentiation_core
  import modexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDTH-1:0]     cfg_data,
  mexp_msg_if.sink                  msg_chan,
  mexp_res_if.source                res_chan
);

  mexp_cmd_t    cmd;
  mexp_status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg_chan.valid),
    .in_ready  (msg_chan.ready),
    .out_valid (res_chan.valid),
    .out_ready (res_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .message    (msg_chan.message),
    .cmd        (cmd),
    .status     (status),
    .result     (res_chan.result),
    .error_code (res_chan.error_code)
  );

endmodule

`default_nettype wire
